// File: hdl/uat_pkg.sv
// shared constants, codes and types of the uid allow table
`default_nettype none
package uat_pkg;

	localparam int ENTRIES = 256;

	localparam int UID_W = 64;

	// operation codes
	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_ADD    = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;
	localparam logic [1:0] FUNC_RSVD   = 2'd3;

	// tag function and version codes
	localparam logic [5:0] TAGFN_MASTER = 6'd6;
	localparam logic [5:0] TAGFN_BACKUP = 6'd10;
	localparam logic [7:0] VERSION_ONE  = 8'd1;
	localparam logic [7:0] BACKUP_TRUSTED = 8'd1;

	// status codes
	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_ZERO_ID   = 3'd4;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic [UID_W-1:0] key;
		logic             is_remove;
		logic             trusted;
		logic             master;
		logic             commit;
	} cmd_t;

	// token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
		logic empty_seen;
	} tok_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// File: hdl/uat_cell.sv
// one table slot: identifier, trusted and master bits, and the token stage
`default_nettype none
module uat_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire uat_pkg::cmd_t cmd,
	input  wire uat_pkg::tok_t tok_in,
	output uat_pkg::tok_t      tok_out
);
	import uat_pkg::*;

	logic [UID_W-1:0] entry_q;
	logic             trusted_q;
	logic             master_q;
	logic             claim_q;
	tok_t             tok_q;
	logic             match;
	logic             empty;

	assign match = (entry_q == cmd.key);
	assign empty = (entry_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q   <= '0;
			trusted_q <= 1'b0;
			master_q  <= 1'b0;
			claim_q   <= 1'b0;
			tok_q     <= '0;
		end else begin
			tok_q.valid      <= tok_in.valid;
			tok_q.found      <= tok_in.found | (tok_in.valid & match);
			tok_q.empty_seen <= tok_in.empty_seen | (tok_in.valid & empty);
			if (tok_in.valid) begin
				// lowest empty slot of this pass claims the pending add
				claim_q <= empty & ~tok_in.empty_seen;
				if (cmd.is_remove && match) begin
					entry_q   <= '0;
					trusted_q <= 1'b0;
					master_q  <= 1'b0;
				end
			end else if (cmd.commit && claim_q) begin
				entry_q   <= cmd.key;
				trusted_q <= cmd.trusted;
				master_q  <= cmd.master;
				claim_q   <= 1'b0;
			end
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// File: hdl/uat_ctrl.sv
// command sequencer: accepts transactions, launches the token, forms the result
`default_nettype none
module uat_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           func,
	input  wire logic [63:0]          tag_uid,
	input  wire logic                 trusted_in,
	input  wire logic [5:0]           tag_function,
	input  wire logic [7:0]           tag_version,
	input  wire logic [7:0]           backup_trust_byte,
	output logic                      done,
	output logic                      ok,
	output logic [2:0]                status,
	output uat_pkg::cmd_t             cmd,
	output uat_pkg::tok_t             tok_first,
	input  wire uat_pkg::tok_t        tok_last
);
	import uat_pkg::*;

	state_t           state_q;
	state_t           next_state;
	logic [UID_W-1:0] key_q;
	logic [1:0]       op_q;
	logic             trusted_q;
	logic             master_q;
	logic             inject_q;
	logic             found_q;
	logic             empty_q;
	logic             done_q;
	logic             ok_q;
	logic [2:0]       status_q;
	logic             accept;
	logic             quick;
	logic             trust_new;

	assign accept = start & (state_q == S_IDLE);
	assign quick  = (tag_uid == '0) | (func == FUNC_RSVD);
	assign trust_new = trusted_in | ((tag_function == TAGFN_BACKUP) &&
		(tag_version > VERSION_ONE) && (backup_trust_byte == BACKUP_TRUSTED));

	always_comb begin
		next_state = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !quick) next_state = S_SCAN;
			end
			S_SCAN: begin
				if (tok_last.valid) next_state = S_DONE;
			end
			S_DONE: begin
				next_state = S_IDLE;
			end
			default: begin
				next_state = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy           = (state_q != S_IDLE);
		cmd.key        = key_q;
		cmd.is_remove  = (op_q == FUNC_REMOVE);
		cmd.trusted    = trusted_q;
		cmd.master     = master_q;
		cmd.commit     = (state_q == S_DONE) && (op_q == FUNC_ADD) && !found_q && empty_q;
		tok_first.valid      = inject_q;
		tok_first.found      = 1'b0;
		tok_first.empty_seen = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			inject_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= next_state;
			inject_q <= accept & ~quick;
			done_q   <= (accept & quick) | (state_q == S_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= tag_uid;
			op_q      <= func;
			trusted_q <= trust_new;
			master_q  <= (tag_function == TAGFN_MASTER);
		end
		if (tok_last.valid) begin
			found_q <= tok_last.found;
			empty_q <= tok_last.empty_seen;
		end
		if (accept && quick) begin
			ok_q     <= 1'b0;
			status_q <= (tag_uid == '0) ? ST_ZERO_ID : ST_NOT_FOUND;
		end else if (state_q == S_DONE) begin
			case (op_q)
				FUNC_LOOKUP: begin
					ok_q     <= found_q;
					status_q <= found_q ? ST_DONE : ST_NOT_FOUND;
				end
				FUNC_ADD: begin
					if (found_q) begin
						ok_q     <= 1'b1;
						status_q <= ST_PRESENT;
					end else begin
						ok_q     <= empty_q;
						status_q <= empty_q ? ST_DONE : ST_FULL;
					end
				end
				FUNC_REMOVE: begin
					ok_q     <= 1'b1;
					status_q <= ST_DONE;
				end
				default: begin
					ok_q     <= 1'b0;
					status_q <= ST_NOT_FOUND;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign ok     = ok_q;
	assign status = status_q;

endmodule
`default_nettype wire

// File: hdl/uid_allow_table_core.sv
// Allow table of 256 64-bit tag identifiers held in a chain of slot cells. A transaction
// is taken when start is high and busy is low. A zero identifier or the unused operation
// code finishes at once: its result strobes on done in the next cycle and busy stays low.
// Every other transaction sends a token down the chain one slot per clock, with busy high
// meanwhile; an add writes the lowest empty slot in the cycle of its done strobe. ok and
// status hold until the next result and are first valid in the single cycle that done is
// high; the receiver must take them then. The table is empty after reset.
`default_nettype none
module uid_allow_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [63:0] tag_uid,
	input  wire logic        trusted_in,
	input  wire logic [5:0]  tag_function,
	input  wire logic [7:0]  tag_version,
	input  wire logic [7:0]  backup_trust_byte,
	output logic             done,
	output logic             ok,
	output logic [2:0]       status
);
	import uat_pkg::*;

	cmd_t cmd;
	tok_t tok_chain [ENTRIES+1];

	uat_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.func              (func),
		.tag_uid           (tag_uid),
		.trusted_in        (trusted_in),
		.tag_function      (tag_function),
		.tag_version       (tag_version),
		.backup_trust_byte (backup_trust_byte),
		.done              (done),
		.ok                (ok),
		.status            (status),
		.cmd               (cmd),
		.tok_first         (tok_chain[0]),
		.tok_last          (tok_chain[ENTRIES])
	);

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		uat_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1])
		);
	end

endmodule
`default_nettype wire
